/* design/cpfq_pkg.sv */
// Shared types and constants of the CAN priority frame queue.
package cpfq_pkg;

  localparam int ID_W        = 11;
  localparam int DLC_W       = 4;
  localparam int DATA_W      = 64;
  localparam int RES_W       = 5;
  localparam int MAX_RESULTS = 16;
  localparam int SCORE_W     = 13;

  localparam logic [SCORE_W-1:0] RR_OFFSET = 13'h1000;

  localparam logic OP_SEND     = 1'b0;
  localparam logic OP_RECEIVE  = 1'b1;
  localparam logic STAT_OK     = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DLC_W-1:0]  dlc;
    logic [DATA_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic            vld;
    logic            first;
    logic            shift;
    logic [ID_W-1:0] pivot;
  } scan_ctl_t;

endpackage

/* design/cpfq_mem.sv */
// Frame store: one write port, one registered read port.
module cpfq_mem #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  cpfq_pkg::entry_t      wdata,
  input  logic [ADDR_W-1:0]     raddr,
  output cpfq_pkg::entry_t      rdata
);

  cpfq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/cpfq_scan.sv */
// Shared score compare unit: keeps the lowest-score entry seen during a scan.
module cpfq_scan #(
  parameter int IDX_W = 4
) (
  input  logic                  clk,
  input  cpfq_pkg::scan_ctl_t   ctl,
  input  logic [IDX_W-1:0]      idx,
  input  cpfq_pkg::entry_t      word,
  output cpfq_pkg::entry_t      best,
  output logic [IDX_W-1:0]      best_idx
);

  logic [cpfq_pkg::SCORE_W-1:0] best_score;
  logic [cpfq_pkg::SCORE_W-1:0] score;
  logic                         hit;

  always_comb begin
    hit   = ctl.shift && (word.id <= ctl.pivot);
    score = {2'b00, word.id} + (hit ? cpfq_pkg::RR_OFFSET : '0);
  end

  // strict compare keeps the earliest arrival on equal scores
  always_ff @(posedge clk) begin
    if (ctl.vld && (ctl.first || (score < best_score))) begin
      best_score <= score;
      best       <= word;
      best_idx   <= idx;
    end
  end

endmodule

/* design/can_priority_frame_queue_core.sv */
// Top level of the CAN priority frame queue: sequencer, store and compare unit.
//
//   channel   direction  handshake                 payload
//   command   in         start, busy               operation, frame_id, frame_dlc,
//                                                  frame_data, request_count
//   config    in         cfg_valid, cfg_ready      cfg_data (round-robin enable)
//   result    out        result_valid (strobe)     status, frame_valid, out_id, out_dlc,
//                                                  out_data, remaining, last
//
// A send gives its result in the cycle after start; busy stays low.
// A receive leaves idle on start, then for each returned frame scans the held entries and
// emits the best one through the single store read port, then compacts the entries above
// it unless it was the last held entry.
// An empty receive or a full send answers in the cycle after start.
// Synchronous reset empties the queue; no clearing pass is needed.
// Results are strobed for one cycle and cannot be held off.
module can_priority_frame_queue_core #(
  parameter int CAPACITY = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            operation,
  input  logic [cpfq_pkg::ID_W-1:0]       frame_id,
  input  logic [cpfq_pkg::DLC_W-1:0]      frame_dlc,
  input  logic [cpfq_pkg::DATA_W-1:0]     frame_data,
  input  logic [cpfq_pkg::RES_W-1:0]      request_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data,
  output logic                            result_valid,
  output logic                            status,
  output logic                            frame_valid,
  output logic [cpfq_pkg::ID_W-1:0]       out_id,
  output logic [cpfq_pkg::DLC_W-1:0]      out_dlc,
  output logic [cpfq_pkg::DATA_W-1:0]     out_data,
  output logic [cpfq_pkg::RES_W-1:0]      remaining,
  output logic                            last
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int EXT_W = CNT_W + cpfq_pkg::RES_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_EMIT,
    ST_SHIFT,
    ST_DRAIN
  } state_t;

  state_t                       state;
  logic [CNT_W-1:0]             occ;
  logic [CNT_W-1:0]             occ_final;
  logic [cpfq_pkg::RES_W-1:0]   n_q;
  logic [cpfq_pkg::RES_W-1:0]   k_q;
  logic [IDX_W-1:0]             ptr;
  logic                         shift_q;
  logic [cpfq_pkg::ID_W-1:0]    pivot_q;
  logic                         rr_en;
  logic                         served_valid;
  logic [cpfq_pkg::ID_W-1:0]    last_served;
  logic                         rd_vld;
  logic [IDX_W-1:0]             rd_idx;
  logic                         wb_pend;
  logic [IDX_W-1:0]             wb_addr;

  logic                         mem_we;
  logic [IDX_W-1:0]             mem_waddr;
  cpfq_pkg::entry_t             mem_wdata;
  logic [IDX_W-1:0]             mem_raddr;
  cpfq_pkg::entry_t             mem_rdata;
  cpfq_pkg::scan_ctl_t          scan_ctl;
  cpfq_pkg::entry_t             best;
  logic [IDX_W-1:0]             best_idx;

  logic                         full;
  logic [IDX_W-1:0]             ptr_inc;
  logic [CNT_W-1:0]             occ_dec;
  logic [CNT_W-1:0]             occ_inc;
  logic [EXT_W-1:0]             req_ext;
  logic [EXT_W-1:0]             occ_ext;
  logic [EXT_W-1:0]             n_min;
  logic [EXT_W-1:0]             n_cap;
  logic [cpfq_pkg::RES_W-1:0]   n_take;
  logic [EXT_W-1:0]             occ_rem_ext;
  logic [EXT_W-1:0]             inc_rem_ext;
  logic [EXT_W-1:0]             fin_rem_ext;
  logic                         is_last;

  always_comb begin
    full        = (occ == CNT_W'(CAPACITY));
    ptr_inc     = ptr + IDX_W'(1);
    occ_dec     = occ - CNT_W'(1);
    occ_inc     = occ + CNT_W'(1);
    req_ext     = {{CNT_W{1'b0}}, request_count};
    occ_ext     = {{cpfq_pkg::RES_W{1'b0}}, occ};
    n_min       = (req_ext < occ_ext) ? req_ext : occ_ext;
    n_cap       = (n_min > EXT_W'(cpfq_pkg::MAX_RESULTS)) ?
                  EXT_W'(cpfq_pkg::MAX_RESULTS) : n_min;
    n_take      = n_cap[cpfq_pkg::RES_W-1:0];
    occ_rem_ext = {{cpfq_pkg::RES_W{1'b0}}, occ};
    inc_rem_ext = {{cpfq_pkg::RES_W{1'b0}}, occ_inc};
    fin_rem_ext = {{cpfq_pkg::RES_W{1'b0}}, occ_final};
    is_last     = ((k_q + cpfq_pkg::RES_W'(1)) == n_q);
  end

  always_comb begin
    mem_we    = wb_pend ||
                ((state == ST_IDLE) && start && (operation == cpfq_pkg::OP_SEND) && !full);
    mem_waddr = wb_pend ? wb_addr : occ[IDX_W-1:0];
    mem_wdata = wb_pend ? mem_rdata :
                cpfq_pkg::entry_t'{id: frame_id, dlc: frame_dlc, data: frame_data};
    mem_raddr = (state == ST_SHIFT) ? ptr_inc : ptr;
    scan_ctl  = '{vld: rd_vld, first: (rd_idx == '0), shift: shift_q, pivot: pivot_q};
  end

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  cpfq_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cpfq_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk      (clk),
    .ctl      (scan_ctl),
    .idx      (rd_idx),
    .word     (mem_rdata),
    .best     (best),
    .best_idx (best_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      occ          <= '0;
      rr_en        <= 1'b0;
      served_valid <= 1'b0;
      last_served  <= '0;
      result_valid <= 1'b0;
      rd_vld       <= 1'b0;
      wb_pend      <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      wb_pend      <= 1'b0;
      rd_vld       <= (state == ST_SCAN);
      rd_idx       <= ptr;
      if (cfg_valid && cfg_ready) begin
        rr_en <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            result_valid <= 1'b1;
            frame_valid  <= 1'b0;
            out_id       <= '0;
            out_dlc      <= '0;
            out_data     <= '0;
            last         <= 1'b1;
            status       <= cpfq_pkg::STAT_OK;
            remaining    <= occ_rem_ext[cpfq_pkg::RES_W-1:0];
            if (operation == cpfq_pkg::OP_SEND) begin
              if (full) begin
                status <= cpfq_pkg::STATUS_FULL;
              end else begin
                occ       <= occ_inc;
                remaining <= inc_rem_ext[cpfq_pkg::RES_W-1:0];
              end
            end else if (n_take != '0) begin
              result_valid <= 1'b0;
              n_q          <= n_take;
              k_q          <= '0;
              occ_final    <= occ - n_cap[CNT_W-1:0];
              shift_q      <= rr_en && served_valid;
              pivot_q      <= last_served;
              ptr          <= '0;
              state        <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (CNT_W'(ptr) == occ_dec) begin
            state <= ST_WAIT;
          end else begin
            ptr <= ptr_inc;
          end
        end
        ST_WAIT: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          result_valid <= 1'b1;
          status       <= cpfq_pkg::STAT_OK;
          frame_valid  <= 1'b1;
          out_id       <= best.id;
          out_dlc      <= best.dlc;
          out_data     <= best.data;
          remaining    <= fin_rem_ext[cpfq_pkg::RES_W-1:0];
          last         <= is_last;
          k_q          <= k_q + cpfq_pkg::RES_W'(1);
          occ          <= occ_dec;
          if (is_last && rr_en) begin
            last_served  <= best.id;
            served_valid <= 1'b1;
          end
          if (CNT_W'(best_idx) < occ_dec) begin
            ptr   <= best_idx;
            state <= ST_SHIFT;
          end else if (is_last) begin
            state <= ST_IDLE;
          end else begin
            ptr   <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SHIFT: begin
          wb_pend <= 1'b1;
          wb_addr <= ptr;
          if (CNT_W'(ptr) == occ_dec) begin
            state <= ST_DRAIN;
          end else begin
            ptr <= ptr_inc;
          end
        end
        ST_DRAIN: begin
          if (k_q == n_q) begin
            state <= ST_IDLE;
          end else begin
            ptr   <= '0;
            state <= ST_SCAN;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/cpfq_check.sv */
// Port-level checks of the CAN priority frame queue, bound to the top level.
module cpfq_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            operation,
  input logic [cpfq_pkg::RES_W-1:0]      request_count,
  input logic                            result_valid,
  input logic                            status,
  input logic                            frame_valid,
  input logic                            last
);

  a_send_answers: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == cpfq_pkg::OP_SEND)) |=> (result_valid && last))
    else $error("send transaction not answered in the next cycle");

  a_empty_request: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == cpfq_pkg::OP_RECEIVE) && (request_count == '0))
    |=> (result_valid && !frame_valid && last))
    else $error("zero-count receive did not give one empty result");

  a_full_no_frame: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status == cpfq_pkg::STATUS_FULL)) |-> (!frame_valid && last))
    else $error("full status carries a frame or is not final");

  a_more_to_come: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> busy)
    else $error("idle while results of a receive are outstanding");

  a_frame_ok: assert property (@(posedge clk) disable iff (rst)
    (result_valid && frame_valid) |-> (status == cpfq_pkg::STAT_OK))
    else $error("dequeued frame with non-ok status");

endmodule

bind can_priority_frame_queue_core cpfq_check u_cpfq_check (.*);

/* verif/tb_can_priority_frame_queue_core.sv */
// Self-checking testbench of the CAN priority frame queue: scoreboard, drivers and stimulus.
`timescale 1ns / 1ps

module tb_can_priority_frame_queue_core;

  localparam int QUEUE_DEPTH    = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 64;

  typedef struct packed {
    logic                          status;
    logic                          frame_valid;
    logic [cpfq_pkg::ID_W-1:0]     id;
    logic [cpfq_pkg::DLC_W-1:0]    dlc;
    logic [cpfq_pkg::DATA_W-1:0]   data;
    logic [cpfq_pkg::RES_W-1:0]    remaining;
    logic                          last;
  } frame_result_t;

  class priority_queue_scoreboard;
    cpfq_pkg::entry_t              held_frames[$];
    frame_result_t                 awaited_results[$];
    logic                          rr_enable;
    logic                          served_any;
    logic [cpfq_pkg::ID_W-1:0]     last_served;
    int                            errors;

    function new();
      rr_enable   = 1'b0;
      served_any  = 1'b0;
      last_served = '0;
      errors      = 0;
    endfunction

    function void set_round_robin(logic value);
      rr_enable = value;
    endfunction

    function logic [cpfq_pkg::SCORE_W-1:0] rr_score(logic [cpfq_pkg::ID_W-1:0] id,
                                                    logic shift,
                                                    logic [cpfq_pkg::ID_W-1:0] pivot);
      if (shift && id <= pivot) return cpfq_pkg::RR_OFFSET + cpfq_pkg::SCORE_W'(id);
      return cpfq_pkg::SCORE_W'(id);
    endfunction

    function void note_command(logic op, logic [cpfq_pkg::ID_W-1:0] id,
                               logic [cpfq_pkg::DLC_W-1:0] dlc,
                               logic [cpfq_pkg::DATA_W-1:0] data,
                               logic [cpfq_pkg::RES_W-1:0] count);
      frame_result_t                  res;
      frame_result_t                  served[$];
      cpfq_pkg::entry_t               frame;
      int                             n;
      int                             best;
      logic                           shift;
      logic [cpfq_pkg::ID_W-1:0]      pivot;
      logic [cpfq_pkg::SCORE_W-1:0]   best_score;
      logic [cpfq_pkg::SCORE_W-1:0]   score;
      res      = '0;
      res.last = 1'b1;
      if (op == cpfq_pkg::OP_SEND) begin
        if (held_frames.size() >= QUEUE_DEPTH) begin
          res.status = cpfq_pkg::STATUS_FULL;
        end else begin
          frame.id   = id;
          frame.dlc  = dlc;
          frame.data = data;
          held_frames.push_back(frame);
        end
        res.remaining = cpfq_pkg::RES_W'(held_frames.size());
        awaited_results.push_back(res);
        return;
      end
      n = count;
      if (n > held_frames.size()) n = held_frames.size();
      if (n > cpfq_pkg::MAX_RESULTS) n = cpfq_pkg::MAX_RESULTS;
      if (n == 0) begin
        res.remaining = cpfq_pkg::RES_W'(held_frames.size());
        awaited_results.push_back(res);
        return;
      end
      shift = rr_enable && served_any;
      pivot = last_served;
      for (int k = 0; k < n; k++) begin
        best       = 0;
        best_score = rr_score(held_frames[0].id, shift, pivot);
        for (int i = 1; i < held_frames.size(); i++) begin
          score = rr_score(held_frames[i].id, shift, pivot);
          if (score < best_score) begin
            best_score = score;
            best       = i;
          end
        end
        res             = '0;
        res.status      = cpfq_pkg::STAT_OK;
        res.frame_valid = 1'b1;
        res.id          = held_frames[best].id;
        res.dlc         = held_frames[best].dlc;
        res.data        = held_frames[best].data;
        res.last        = (k == n - 1);
        served.push_back(res);
        held_frames.delete(best);
      end
      if (rr_enable) begin
        last_served = served[n-1].id;
        served_any  = 1'b1;
      end
      foreach (served[k]) begin
        served[k].remaining = cpfq_pkg::RES_W'(held_frames.size());
        awaited_results.push_back(served[k]);
      end
    endfunction

    function void compare_field(string field, logic [63:0] expected, logic [63:0] actual);
      if (actual !== expected) begin
        $error("%s: expected %0h, actual %0h", field, expected, actual);
        errors++;
      end
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (awaited_results.size() == 0) begin
        $error("result with nothing awaited: id %0h, last %0b", got.id, got.last);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("frame_valid", want.frame_valid, got.frame_valid);
      compare_field("out_id", want.id, got.id);
      compare_field("out_dlc", want.dlc, got.dlc);
      compare_field("out_data", want.data, got.data);
      compare_field("remaining", want.remaining, got.remaining);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic                          operation;
  logic [cpfq_pkg::ID_W-1:0]     frame_id;
  logic [cpfq_pkg::DLC_W-1:0]    frame_dlc;
  logic [cpfq_pkg::DATA_W-1:0]   frame_data;
  logic [cpfq_pkg::RES_W-1:0]    request_count;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic                          cfg_data;
  logic                          result_valid;
  logic                          status;
  logic                          frame_valid;
  logic [cpfq_pkg::ID_W-1:0]     out_id;
  logic [cpfq_pkg::DLC_W-1:0]    out_dlc;
  logic [cpfq_pkg::DATA_W-1:0]   out_data;
  logic [cpfq_pkg::RES_W-1:0]    remaining;
  logic                          last;

  priority_queue_scoreboard board = new();
  int idle_cycles = 0;

  can_priority_frame_queue_core #(
    .CAPACITY(QUEUE_DEPTH)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .frame_id     (frame_id),
    .frame_dlc    (frame_dlc),
    .frame_data   (frame_data),
    .request_count(request_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .status       (status),
    .frame_valid  (frame_valid),
    .out_id       (out_id),
    .out_dlc      (out_dlc),
    .out_data     (out_data),
    .remaining    (remaining),
    .last         (last)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    frame_result_t seen;
    if (!rst && result_valid !== 1'b0) begin
      seen.status      = status;
      seen.frame_valid = frame_valid;
      seen.id          = out_id;
      seen.dlc         = out_dlc;
      seen.data        = out_data;
      seen.remaining   = remaining;
      seen.last        = last;
      board.check_result(seen);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic issue_command(logic op, logic [cpfq_pkg::ID_W-1:0] id,
                               logic [cpfq_pkg::DLC_W-1:0] dlc,
                               logic [cpfq_pkg::DATA_W-1:0] data,
                               logic [cpfq_pkg::RES_W-1:0] count, int gap);
    start         <= 1'b1;
    operation     <= op;
    frame_id      <= id;
    frame_dlc     <= dlc;
    frame_data    <= data;
    request_count <= count;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_command(op, id, dlc, data, count);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (board.awaited_results.size() != 0 || busy);
    @(posedge clk);
  endtask

  task automatic write_round_robin(logic value);
    start <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.set_round_robin(value);
  endtask

  task automatic random_command(int recv_weight, bit idling);
    logic                          op;
    logic [cpfq_pkg::ID_W-1:0]     id;
    logic [cpfq_pkg::DLC_W-1:0]    dlc;
    logic [cpfq_pkg::RES_W-1:0]    count;
    int                            gap;
    op = ($urandom_range(0, 9) < recv_weight) ? cpfq_pkg::OP_RECEIVE : cpfq_pkg::OP_SEND;
    case ($urandom_range(0, 3))
      0: id = cpfq_pkg::ID_W'($urandom_range(1000, 1007));
      1: id = $urandom_range(0, 1) ? '1 : '0;
      default: id = cpfq_pkg::ID_W'($urandom_range(0, 2047));
    endcase
    dlc = ($urandom_range(0, 7) == 0) ? cpfq_pkg::DLC_W'($urandom_range(0, 15)) :
                                        cpfq_pkg::DLC_W'($urandom_range(0, 8));
    case ($urandom_range(0, 9))
      0: count = '0;
      1: count = cpfq_pkg::RES_W'($urandom_range(17, 31));
      2: count = 5'd16;
      default: count = cpfq_pkg::RES_W'($urandom_range(1, 4));
    endcase
    gap = (idling && $urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
    issue_command(op, id, dlc, {$urandom(), $urandom()}, count, gap);
  endtask

  initial begin
    logic [cpfq_pkg::ID_W-1:0] id;
    rst           <= 1'b1;
    start         <= 1'b0;
    operation     <= cpfq_pkg::OP_SEND;
    frame_id      <= '0;
    frame_dlc     <= '0;
    frame_data    <= '0;
    request_count <= '0;
    cfg_valid     <= 1'b0;
    cfg_data      <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    write_round_robin(1'b0);
    issue_command(cpfq_pkg::OP_RECEIVE, '0, '0, '0, 5'd0, 0);
    issue_command(cpfq_pkg::OP_RECEIVE, '0, '0, '0, 5'd16, 0);
    issue_command(cpfq_pkg::OP_SEND, '1, 4'd8, '1, 5'd0, 0);
    issue_command(cpfq_pkg::OP_SEND, '0, 4'd0, '0, 5'd0, 0);
    for (int i = 2; i < QUEUE_DEPTH; i++) begin
      id = cpfq_pkg::ID_W'(600 + (i % 4));
      issue_command(cpfq_pkg::OP_SEND, id, 4'(i % 9), {$urandom(), $urandom()}, 5'd0, 0);
    end
    issue_command(cpfq_pkg::OP_SEND, 11'd5, 4'd3, {$urandom(), $urandom()}, 5'd0, 0);
    issue_command(cpfq_pkg::OP_RECEIVE, '0, '0, '0, 5'd0, 0);
    issue_command(cpfq_pkg::OP_RECEIVE, '0, '0, '0, 5'd31, 0);

    write_round_robin(1'b1);
    issue_command(cpfq_pkg::OP_SEND, 11'd300, 4'd1, {$urandom(), $urandom()}, 5'd0, 0);
    issue_command(cpfq_pkg::OP_SEND, 11'd100, 4'd2, {$urandom(), $urandom()}, 5'd0, 0);
    issue_command(cpfq_pkg::OP_SEND, 11'd300, 4'd3, {$urandom(), $urandom()}, 5'd0, 0);
    issue_command(cpfq_pkg::OP_RECEIVE, '0, '0, '0, 5'd1, 0);
    issue_command(cpfq_pkg::OP_SEND, 11'd50, 4'd4, {$urandom(), $urandom()}, 5'd0, 0);
    issue_command(cpfq_pkg::OP_SEND, 11'd100, 4'd5, {$urandom(), $urandom()}, 5'd0, 0);
    issue_command(cpfq_pkg::OP_RECEIVE, '0, '0, '0, 5'd31, 0);

    for (int phase = 0; phase < 4; phase++) begin
      write_round_robin(phase % 2 == 0);
      for (int n = 0; n < 56; n++) begin
        random_command((phase == 1) ? 5 : (phase == 0) ? 2 : 4, phase < 3);
      end
    end

    start <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* can_priority_frame_queue_core.f */
design/cpfq_pkg.sv
design/cpfq_mem.sv
design/cpfq_scan.sv
design/can_priority_frame_queue_core.sv
design/cpfq_check.sv
verif/tb_can_priority_frame_queue_core.sv
